>>> hw/rtl/bpgs_pkg.sv
// Shared widths and opcode codes for the bit-parallel gate simulator.
package bpgs_pkg;

  localparam int unsigned NUM_VARS = 1024;
  localparam int unsigned VEC_BITS = 64;
  localparam int unsigned IDX_W    = $clog2(NUM_VARS);
  localparam int unsigned OP_W     = 3;
  localparam int unsigned IN_DATA_W = ((IDX_W + 1 + VEC_BITS + 7) / 8) * 8;

  typedef logic [VEC_BITS-1:0] vec_t;
  typedef logic [IDX_W-1:0]    idx_t;

  typedef enum logic [OP_W-1:0] {
    OP_LOAD       = 3'd0,
    OP_READ       = 3'd1,
    OP_BEGIN_GATE = 3'd2,
    OP_LITERAL    = 3'd3,
    OP_END_CLAUSE = 3'd4,
    OP_END_GATE   = 3'd5
  } op_t;

endpackage

>>> hw/rtl/bpgs_vec_mem.sv
// Simulation vector store: one write port, one registered read port with enable.
module bpgs_vec_mem (
  input  logic           clk,
  input  logic           wr_en,
  input  bpgs_pkg::idx_t wr_addr,
  input  bpgs_pkg::vec_t wr_data,
  input  logic           rd_en,
  input  bpgs_pkg::idx_t rd_addr,
  output bpgs_pkg::vec_t rd_data
);

  bpgs_pkg::vec_t mem [bpgs_pkg::NUM_VARS];
  bpgs_pkg::vec_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // read-first: a same-cycle write is seen only through the caller's bypass
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

>>> hw/rtl/bit_parallel_gate_simulation.sv
// Top level of the bit-parallel gate simulator: token pipeline around the vector store.
//
// Usage:
//   Input beats carry one token each. in_tuser holds the opcode (load, read,
//   begin gate, literal, end clause, end gate); in_tdata holds var_index,
//   negative and vec_data. Only a read token produces an output beat, whose
//   out_tdata is the 64-bit vector of the addressed variable.
//   Timing: a token is accepted, its vector read is issued to the store in the
//   same cycle, and the next cycle it updates the clause sum, gate product or
//   store. A read result passes the execute stage and the output register
//   to out_tvalid. Throughput is one token per cycle unless a read waits on
//   the receiver; a dependent read after a write is bypassed without a bubble.
//   When the receiver stalls, a read token waits in the execute stage until the
//   output register frees; in_tready drops only in that case. Other tokens keep
//   flowing behind a pending output beat.
//   Reset: the gate product goes to all ones, the clause sum to zero, the gate
//   output variable and sign to zero, and both pipeline stages empty. Vectors
//   in the store are undefined until loaded or written by end gate.
module bit_parallel_gate_simulation (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [bpgs_pkg::OP_W-1:0]      in_tuser,   // [2:0] opcode
  // [9:0] var_index, [10] negative, [74:11] vec_data, zero pad
  input  logic [bpgs_pkg::IN_DATA_W-1:0] in_tdata,
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [bpgs_pkg::VEC_BITS-1:0]  out_tdata   // [63:0] read_data
);

  localparam int unsigned IW = bpgs_pkg::IDX_W;
  localparam int unsigned VW = bpgs_pkg::VEC_BITS;

  // input unpack
  bpgs_pkg::op_t  in_op;
  bpgs_pkg::idx_t in_idx;
  logic           in_neg;
  bpgs_pkg::vec_t in_vec;

  assign in_op  = bpgs_pkg::op_t'(in_tuser);
  assign in_idx = in_tdata[IW-1:0];
  assign in_neg = in_tdata[IW];
  assign in_vec = in_tdata[IW+VW:IW+1];

  // execute stage
  logic           s1_valid_r;
  bpgs_pkg::op_t  s1_op_r;
  bpgs_pkg::idx_t s1_idx_r;
  logic           s1_neg_r;
  bpgs_pkg::vec_t s1_data_r;
  logic           fwd_hit_r;
  bpgs_pkg::vec_t fwd_data_r;

  // architectural state
  bpgs_pkg::vec_t gate_product_r, gate_product_nxt;
  bpgs_pkg::vec_t clause_sum_r,   clause_sum_nxt;
  bpgs_pkg::idx_t gate_var_r,     gate_var_nxt;
  logic           gate_neg_r,     gate_neg_nxt;

  // output register
  logic           out_valid_r;
  bpgs_pkg::vec_t out_data_r;

  logic           s1_go;
  logic           in_fire;
  logic           wr_en;
  bpgs_pkg::idx_t wr_addr;
  bpgs_pkg::vec_t wr_data;
  bpgs_pkg::vec_t mem_q;
  bpgs_pkg::vec_t s1_vec;

  assign s1_go     = !(s1_op_r == bpgs_pkg::OP_READ) || !out_valid_r || out_tready;
  assign in_tready = !s1_valid_r || s1_go;
  assign in_fire   = in_tvalid && in_tready;

  assign s1_vec = fwd_hit_r ? fwd_data_r : mem_q;

  always_comb begin
    gate_product_nxt = gate_product_r;
    clause_sum_nxt   = clause_sum_r;
    gate_var_nxt     = gate_var_r;
    gate_neg_nxt     = gate_neg_r;
    wr_en            = 1'b0;
    wr_addr          = s1_idx_r;
    wr_data          = s1_data_r;
    if (s1_valid_r && s1_go) begin
      unique case (s1_op_r)
        bpgs_pkg::OP_LOAD: begin
          wr_en = 1'b1;
        end
        bpgs_pkg::OP_READ: begin
        end
        bpgs_pkg::OP_BEGIN_GATE: begin
          gate_var_nxt     = s1_idx_r;
          gate_neg_nxt     = s1_neg_r;
          gate_product_nxt = '1;
          clause_sum_nxt   = '0;
        end
        bpgs_pkg::OP_LITERAL: begin
          // literals on the gate's own output are skipped
          if (s1_idx_r != gate_var_r) begin
            clause_sum_nxt = clause_sum_r | (s1_neg_r ? s1_vec : ~s1_vec);
          end
        end
        bpgs_pkg::OP_END_CLAUSE: begin
          gate_product_nxt = gate_product_r & clause_sum_r;
          clause_sum_nxt   = '0;
        end
        bpgs_pkg::OP_END_GATE: begin
          wr_en            = 1'b1;
          wr_addr          = gate_var_r;
          wr_data          = gate_neg_r ? ~gate_product_r : gate_product_r;
          gate_product_nxt = '1;
          clause_sum_nxt   = '0;
        end
        default: begin
        end
      endcase
    end
  end

  bpgs_vec_mem u_vec_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (in_fire),
    .rd_addr (in_idx),
    .rd_data (mem_q)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r     <= 1'b0;
      out_valid_r    <= 1'b0;
      gate_product_r <= '1;
      clause_sum_r   <= '0;
      gate_var_r     <= '0;
      gate_neg_r     <= 1'b0;
      fwd_hit_r      <= 1'b0;
    end else begin
      gate_product_r <= gate_product_nxt;
      clause_sum_r   <= clause_sum_nxt;
      gate_var_r     <= gate_var_nxt;
      gate_neg_r     <= gate_neg_nxt;

      if (in_fire) begin
        s1_valid_r <= 1'b1;
        // store reads old data on a same-address write; bypass it
        fwd_hit_r  <= wr_en && (wr_addr == in_idx);
      end else if (s1_go) begin
        s1_valid_r <= 1'b0;
      end

      if (s1_valid_r && s1_go && (s1_op_r == bpgs_pkg::OP_READ)) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_op_r    <= in_op;
      s1_idx_r   <= in_idx;
      s1_neg_r   <= in_neg;
      s1_data_r  <= in_vec;
      fwd_data_r <= wr_data;
    end
    if (s1_valid_r && s1_go && (s1_op_r == bpgs_pkg::OP_READ)) begin
      out_data_r <= s1_vec;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule
